// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// implication checked in the cycle after the condition
`define CHK_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== src/lew_pkg.sv =====
// shared types and constants of the loop-erased walk builder
package lew_pkg;
  localparam int MaxSteps = 64;
  localparam int MaxDim = 3;
  localparam int PosBits = 24;
  localparam int AxisBits = PosBits / MaxDim;
  localparam int IdxBits = $clog2(MaxSteps);
  localparam int LenBits = $clog2(MaxSteps + 1);

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [LenBits-1:0] len_t;

  localparam logic [1:0] StExtend = 2'd0;
  localparam logic [1:0] StLoop = 2'd1;
  localparam logic [1:0] StOrigin = 2'd2;
  localparam logic [1:0] StIgnore = 2'd3;

  localparam logic CfgDims = 1'b0;
  localparam logic CfgTarget = 1'b1;

  // store write request
  typedef struct packed {
    logic we;
    idx_t addr;
    pos_t pos;
    logic [2:0] dir;
  } wr_req_t;

  // move the head one unit along one axis, wrapping per coordinate
  function automatic pos_t move_one(pos_t pos, logic [1:0] axis, logic minus);
    pos_t res;
    logic [AxisBits-1:0] f;
    res = pos;
    for (int a = 0; a < MaxDim; a++) begin
      if (axis == a[1:0]) begin
        f = pos[a*AxisBits +: AxisBits];
        f = minus ? f - 1'b1 : f + 1'b1;
        res[a*AxisBits +: AxisBits] = f;
      end
    end
    return res;
  endfunction
endpackage

// ===== src/lew_store.sv =====
// walk step and position memories, one write and one registered read port
module lew_store (
  input  logic            clk,
  input  lew_pkg::wr_req_t wr,
  input  lew_pkg::idx_t   rd_addr,
  output lew_pkg::pos_t   rd_pos
);
  import lew_pkg::*;

  pos_t       pos_mem [MaxSteps];
  logic [2:0] step_mem [MaxSteps];

  // write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      pos_mem[wr.addr] <= wr.pos;
      step_mem[wr.addr] <= wr.dir;
    end
  end

  // registered read of positions
  always_ff @(posedge clk) begin
    rd_pos <= pos_mem[rd_addr];
  end
endmodule

// ===== src/loop_erased_walk_builder_top.sv =====
// top level of the loop-erased walk builder
// One word in, one result out. A step searches the walk for the new position
// one entry at a time and passes through the search state even on an empty
// walk; the position memory has one read port and the search reads one entry
// per cycle. busy stays high through the cycle of the result strobe; the
// result is shown for one cycle and cannot be stalled. Ignored directions and
// returns to the origin skip the search and go straight to the result.
module loop_erased_walk_builder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_direction,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [6:0] out_walk_length,
  output logic       out_complete,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);
  import lew_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] dims_r;
  logic [6:0] target_r;
  pos_t head_r, head_nxt, p_r, p_nxt;
  len_t len_r, len_nxt, k_r, k_nxt;
  logic [2:0] dir_r, dir_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;
  logic [6:0] olen_r, olen_nxt;
  logic cmpl_r, cmpl_nxt;
  wr_req_t wr;
  idx_t rd_addr;
  pos_t rd_pos;
  logic rd_ok_r, rd_ok_nxt;
  logic [1:0] dims_eff;
  len_t target_eff;
  pos_t p_new;

  lew_store u_store (.clk(clk), .wr(wr), .rd_addr(rd_addr), .rd_pos(rd_pos));

  assign cfg_ready = 1'b1;
  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_walk_length = olen_r;
  assign out_complete = cmpl_r;

  // effective configuration
  always_comb begin
    dims_eff = (dims_r > 2'(MaxDim)) ? 2'(MaxDim) : dims_r;
    if (target_r == 7'd0) target_eff = len_t'(1);
    else if (32'(target_r) > MaxSteps) target_eff = len_t'(MaxSteps);
    else target_eff = len_t'(target_r);
  end

  assign p_new = move_one(head_r, in_direction[2:1], in_direction[0]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= 2'd2;
      target_r <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CfgDims) dims_r <= cfg_data[1:0];
      else target_r <= cfg_data;
    end
  end

  // step sequencer
  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    len_nxt = len_r;
    k_nxt = k_r;
    p_nxt = p_r;
    dir_nxt = dir_r;
    rd_ok_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    status_nxt = status_r;
    olen_nxt = olen_r;
    cmpl_nxt = 1'b0;
    wr = '0;
    rd_addr = k_r[IdxBits-1:0];
    unique case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (start) begin
          dir_nxt = in_direction;
          p_nxt = p_new;
          k_nxt = '0;
          if ({1'b0, in_direction[2:1]} >= {1'b0, dims_eff}) begin
            status_nxt = StIgnore;
            olen_nxt = 7'(len_r);
            state_nxt = S_DONE;
            out_valid_nxt = 1'b1;
          end else if (p_new == '0) begin
            status_nxt = StOrigin;
            olen_nxt = '0;
            len_nxt = '0;
            head_nxt = '0;
            cmpl_nxt = (target_eff == '0);
            state_nxt = S_DONE;
            out_valid_nxt = 1'b1;
          end else begin
            rd_ok_nxt = 1'b1;
            k_nxt = len_t'(1);
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // rd_pos holds entry k_r-1
        if (rd_ok_r && (k_r <= len_r) && rd_pos == p_r) begin
          len_nxt = k_r;
          head_nxt = p_r;
          status_nxt = StLoop;
          olen_nxt = 7'(k_r);
          state_nxt = S_DONE;
          out_valid_nxt = 1'b1;
        end else if (k_r >= len_r || k_r == '0) begin
          head_nxt = p_r;
          status_nxt = StExtend;
          if (32'(len_r) < MaxSteps) begin
            wr.we = 1'b1;
            wr.addr = len_r[IdxBits-1:0];
            wr.pos = p_r;
            wr.dir = dir_r;
            len_nxt = len_r + 1'b1;
            olen_nxt = 7'(len_r + 1'b1);
          end else begin
            olen_nxt = 7'(len_r);
          end
          state_nxt = S_DONE;
          out_valid_nxt = 1'b1;
        end else begin
          rd_ok_nxt = 1'b1;
          k_nxt = k_r + 1'b1;
        end
        if (k_r == '0) begin
          rd_ok_nxt = 1'b1;
          k_nxt = len_t'(1);
          state_nxt = S_SRCH;
          out_valid_nxt = 1'b0;
          wr = '0;
          len_nxt = len_r;
          head_nxt = head_r;
        end
        // completion check
        if (out_valid_nxt && 7'(len_nxt) >= 7'(target_eff)) begin
          cmpl_nxt = 1'b1;
          len_nxt = '0;
          head_nxt = '0;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      len_r <= '0;
      out_valid_r <= 1'b0;
      cmpl_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      len_r <= len_nxt;
      out_valid_r <= out_valid_nxt;
      cmpl_r <= cmpl_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    p_r <= p_nxt;
    dir_r <= dir_nxt;
    status_r <= status_nxt;
    olen_r <= olen_nxt;
  end

  `CHK_IMPL(a_len_max, clk, rst_n, 1'b1, 32'(len_r) <= MaxSteps, "walk length overflow")
  `CHK_IMPL(a_cmpl_strobe, clk, rst_n, out_complete, out_valid, "complete without strobe")
  `CHK_NEXT(a_cmpl_restart, clk, rst_n, out_valid_nxt && cmpl_nxt, len_r == '0 && head_r == '0,
            "walk not restarted")
  `CHK_IMPL(a_busy_strobe, clk, rst_n, out_valid, state_r == S_DONE, "strobe outside done")
endmodule
